/* src/fml_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fml_pkg: shared types and constants for the frame memory with LRU ages
// Sizes of the byte store, frame geometry, age counters and beat formats.
// ----------------------------------------------------------------------------
package fml_pkg;

  localparam int FRAME_COUNT = 32;
  localparam int FRAME_BYTES = 256;
  localparam int AGE_BITS    = 16;

  localparam int MEM_BYTES = FRAME_COUNT * FRAME_BYTES;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int OFFS_W    = $clog2(FRAME_BYTES);
  localparam int SCAN_CW   = $clog2(FRAME_COUNT + 1);

  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 13;
  localparam int DATA_W    = 8;
  localparam int FIELD_FW  = 5;

  localparam logic [DATA_W-1:0]   RESET_BYTE = 8'h5F;
  localparam logic [AGE_BITS-1:0] AGE_MAX    = {AGE_BITS{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } fml_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                free_found;
    logic [FIELD_FW-1:0] free_frame;
    logic                victim_found;
    logic [FIELD_FW-1:0] victim_frame;
  } fml_out_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] frame;
  } fml_touch_t;

  typedef struct packed {
    logic                free_found;
    logic [FRAME_W-1:0]  free_idx;
    logic                victim_found;
    logic [FRAME_W-1:0]  victim_idx;
    logic [AGE_BITS-1:0] best_age;
  } fml_scan_t;

endpackage

/* src/frame_memory_with_lru_ages.sv */
`timescale 1ns / 1ps
// Each accepted beat starts a scan in ST_SEARCH; the result beat is registered
// once the scan has walked the frame cell chain, one cell per cycle, and the
// output is free. Input ready stays low until then, so no new beat is taken.
// Reset: all frames unused with age zero; a clearing pass then writes 0x5F to
// every byte, with input ready held low.
// ----------------------------------------------------------------------------
// frame_memory_with_lru_ages: byte memory with per-frame LRU age tracking
// Byte reads and writes set the touched frame to age zero and age all other frames
// in use; every beat reports the lowest free frame and the oldest frame as victim.
// ----------------------------------------------------------------------------
module frame_memory_with_lru_ages (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fml_pkg::fml_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fml_pkg::fml_out_t out_data_o
);
  import fml_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_SEARCH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [MEM_AW-1:0]   clr_q, clr_d;
  logic [SCAN_CW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  fml_out_t            out_q;
  logic                is_rd_q;
  logic [DATA_W-1:0]   rdata_q;
  logic [DATA_W-1:0]   mem_q [MEM_BYTES];

  logic                accept;
  logic                is_rd, is_wr;
  logic                load;
  logic [MEM_AW-1:0]   mem_addr;
  fml_touch_t          touch;
  fml_scan_t           scan [FRAME_COUNT+1];

  assign accept   = in_valid_i && in_ready_o;
  assign is_rd    = in_data_i.kind == KIND_READ;
  assign is_wr    = in_data_i.kind == KIND_WRITE;
  assign mem_addr = in_data_i.address[MEM_AW-1:0];

  assign touch.en    = accept && (is_rd || is_wr);
  assign touch.frame = in_data_i.address[OFFS_W +: FRAME_W];

  assign scan[0] = '0;

  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    fml_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (FRAME_W'(i)),
      .touch_i    (touch),
      .scan_i     (scan[i]),
      .scan_o     (scan[i+1])
    );
  end

  assign load = (state_q == ST_SEARCH) && (cnt_q == SCAN_CW'(FRAME_COUNT)) &&
                (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + MEM_AW'(1);
        if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_d   = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (cnt_q != SCAN_CW'(FRAME_COUNT)) begin
          cnt_d = cnt_q + SCAN_CW'(1);
        end else if (load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mem_q[clr_q] <= RESET_BYTE;
    end else if (accept && is_wr) begin
      mem_q[mem_addr] <= in_data_i.write_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_rd_q <= is_rd;
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.read_data    <= is_rd_q ? rdata_q : '0;
      out_q.free_found   <= scan[FRAME_COUNT].free_found;
      out_q.free_frame   <= FIELD_FW'(scan[FRAME_COUNT].free_idx);
      out_q.victim_found <= scan[FRAME_COUNT].victim_found;
      out_q.victim_frame <= FIELD_FW'(scan[FRAME_COUNT].victim_idx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SEARCH) && (cnt_q == '0))
    else $error("accepted beat did not start a scan");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_o && !in_ready_o)
    else $error("handshake active during clearing pass");

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_SEARCH) &&
                           $past(cnt_q == SCAN_CW'(FRAME_COUNT)))
    else $error("result loaded before the scan finished");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");
`endif

endmodule

/* src/fml_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fml_cell: one frame of the LRU age chain
// Holds the in-use bit and age of one frame and folds them into the scan
// record passed on to the next cell every cycle.
// ----------------------------------------------------------------------------
module fml_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fml_pkg::FRAME_W-1:0] cell_idx_i,
  input  fml_pkg::fml_touch_t         touch_i,
  input  fml_pkg::fml_scan_t          scan_i,
  output fml_pkg::fml_scan_t          scan_o
);
  import fml_pkg::*;

  logic                in_use_q, in_use_d;
  logic [AGE_BITS-1:0] age_q, age_d;
  fml_scan_t           scan_q, scan_d;

  always_comb begin
    in_use_d = in_use_q;
    age_d    = age_q;
    if (touch_i.en) begin
      if (touch_i.frame == cell_idx_i) begin
        in_use_d = 1'b1;
        age_d    = '0;
      end else if (in_use_q && (age_q != AGE_MAX)) begin
        age_d = age_q + AGE_BITS'(1);
      end
    end
  end

  always_comb begin
    scan_d = scan_i;
    if (!scan_i.free_found && !in_use_q) begin
      scan_d.free_found = 1'b1;
      scan_d.free_idx   = cell_idx_i;
    end
    if (in_use_q && (age_q > scan_i.best_age)) begin
      scan_d.best_age     = age_q;
      scan_d.victim_found = 1'b1;
      scan_d.victim_idx   = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      age_q    <= '0;
      scan_q   <= '0;
    end else begin
      in_use_q <= in_use_d;
      age_q    <= age_d;
      scan_q   <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule
